>>> hdl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants for the point-in-polygon test block.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int COORD_W = 16;
    localparam int CFG_W   = 5;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREV,
        S_LOAD,
        S_CROSS
    } t_state;

    typedef struct packed {
        logic take;      // latch query point
        logic empty;     // no vertices: answer outside
        logic first;     // closing vertex arrives, init box
        logic vertex;    // vertex i arrives, first product
        logic crossing;  // second product, crossing decision
        logic last;      // final edge, deliver answer
    } t_dp_ctrl;

endpackage

>>> hdl/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Crossing-number point-in-polygon test on signed Q8.8 coordinates, with a
// bounding box check, over a vertex store written by load words.
//
//   channel   ports                                      handshake
//   -------   ----------------------------------------   -------------------
//   command   i_func i_vertex_index i_coord_x i_coord_y  start & !busy
//   result    o_inside_res                               o_done, 1 cycle
//   config    i_cfg_wdata (vertex_count)                 i_cfg_we
//
// A load word never raises busy. A test word with n vertices in use holds
// busy through one store read, then a product pass and a crossing pass on
// the multiplier per edge; the result is registered from the final crossing
// pass and strobes in the same cycle a new word can be accepted. With n = 0
// the result strobes on the next cycle. Reset clears control and vertex_count
// only; the vertex store holds no reset value. The receiver cannot stall.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_func,
    input  logic [3:0]                         i_vertex_index,
    input  logic signed [ppt_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [ppt_pkg::COORD_W-1:0] i_coord_y,
    input  logic                               i_cfg_we,
    input  logic [ppt_pkg::CFG_W-1:0]          i_cfg_wdata,
    output logic                               o_done,
    output logic                               o_inside_res
);
    import ppt_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    logic [CFG_W-1:0]         r_vcount;
    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [2*COORD_W-1:0]     ram_rdata;
    t_dp_ctrl                 ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    assign ram_we = start && !busy && (i_func == FUNC_LOAD)
                    && (32'(i_vertex_index) < MAX_VERTICES);

    ppt_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_vertex_index)),
        .i_wdata ({i_coord_x, i_coord_y}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ppt_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_func),
        .i_vcount (r_vcount),
        .o_busy   (busy),
        .o_re     (ram_re),
        .o_raddr  (ram_raddr),
        .o_ctrl   (ctrl)
    );

    ppt_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_qx     (i_coord_x),
        .i_qy     (i_coord_y),
        .i_vx     ($signed(ram_rdata[2*COORD_W-1:COORD_W])),
        .i_vy     ($signed(ram_rdata[COORD_W-1:0])),
        .o_done   (o_done),
        .o_inside (o_inside_res)
    );

endmodule

>>> hdl/ppt_ram.sv
// ----------------------------------------------------------------------------
// ppt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ppt_seq.sv
// ----------------------------------------------------------------------------
// ppt_seq
// Query sequencer: walks the vertex store once, closing vertex first,
// with a product state and a crossing state per vertex on the shared multiplier.
// ----------------------------------------------------------------------------
module ppt_seq #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_func,
    input  logic [ppt_pkg::CFG_W-1:0]       i_vcount,
    output logic                            o_busy,
    output logic                            o_re,
    output logic [$clog2(MAX_VERTICES)-1:0] o_raddr,
    output ppt_pkg::t_dp_ctrl               o_ctrl
);
    import ppt_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

    t_state        r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] cnt_ext, max_c, n_eff;
    logic [AW-1:0] last_idx;
    logic          empty;
    logic          accept;

    assign cnt_ext  = CW'(i_vcount);
    assign max_c    = CW'(MAX_VERTICES);
    assign n_eff    = (cnt_ext > max_c) ? max_c : cnt_ext;
    assign last_idx = AW'(n_eff - CW'(1));
    assign empty    = (n_eff == '0);
    assign accept   = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_ctrl  = '0;
        o_re    = 1'b0;
        o_raddr = r_idx;
        case (r_state)
            S_IDLE: begin
                if (accept && i_func == FUNC_TEST) begin
                    o_ctrl.take = 1'b1;
                    if (empty) begin
                        o_ctrl.empty = 1'b1;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = last_idx;
                        n_state = S_PREV;
                    end
                end
            end
            S_PREV: begin
                o_ctrl.first = 1'b1;
                o_re         = 1'b1;
                o_raddr      = '0;
                n_idx        = '0;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_ctrl.vertex = 1'b1;
                if (r_idx != last_idx) begin
                    o_re    = 1'b1;
                    o_raddr = r_idx + AW'(1);
                end
                n_state = S_CROSS;
            end
            S_CROSS: begin
                o_ctrl.crossing = 1'b1;
                if (r_idx == last_idx) begin
                    o_ctrl.last = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ppt_dp.sv
// ----------------------------------------------------------------------------
// ppt_dp
// Datapath: bounding box tracking, one shared 17x17 multiplier for the
// edge cross products, crossing parity and the result register.
// ----------------------------------------------------------------------------
module ppt_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ppt_pkg::t_dp_ctrl                  i_ctrl,
    input  logic signed [ppt_pkg::COORD_W-1:0] i_qx,
    input  logic signed [ppt_pkg::COORD_W-1:0] i_qy,
    input  logic signed [ppt_pkg::COORD_W-1:0] i_vx,
    input  logic signed [ppt_pkg::COORD_W-1:0] i_vy,
    output logic                               o_done,
    output logic                               o_inside
);
    import ppt_pkg::*;

    logic signed [COORD_W-1:0] r_x, r_y;
    logic signed [COORD_W-1:0] r_xi, r_yi, r_xj, r_yj;
    logic signed [COORD_W-1:0] r_minx, r_maxx, r_miny, r_maxy;
    logic signed [PROD_W-1:0]  r_lhs;
    logic                      r_dx_pos, r_span, r_par;
    logic                      r_done, r_inside;
    logic                      n_done, n_inside;

    logic signed [DIFF_W-1:0]  op_a, op_b, dx_new;
    logic signed [PROD_W-1:0]  prod;
    logic                      below, toggle, in_box;

    function automatic logic signed [DIFF_W-1:0] sub17(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        sub17 = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    endfunction

    assign dx_new = sub17(r_xj, i_vx);

    // shared multiplier: (y - yi) * dx, then dy * (x - xi)
    always_comb begin
        if (i_ctrl.vertex) begin
            op_a = sub17(r_y, i_vy);
            op_b = dx_new;
        end else begin
            op_a = sub17(r_yj, r_yi);
            op_b = sub17(r_x, r_xi);
        end
    end

    assign prod   = op_a * op_b;
    assign below  = r_dx_pos ? (r_lhs < prod) : (r_lhs > prod);
    assign toggle = r_span & below;
    assign in_box = !(r_x < r_minx || r_x > r_maxx || r_y < r_miny || r_y > r_maxy);

    assign n_done   = i_ctrl.empty | i_ctrl.last;
    assign n_inside = i_ctrl.last & in_box & (r_par ^ toggle);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_done) begin
            r_inside <= n_inside;
        end
        if (i_ctrl.take) begin
            r_x <= i_qx;
            r_y <= i_qy;
        end
        if (i_ctrl.first) begin
            r_xj   <= i_vx;
            r_yj   <= i_vy;
            r_minx <= i_vx;
            r_maxx <= i_vx;
            r_miny <= i_vy;
            r_maxy <= i_vy;
            r_par  <= 1'b0;
        end
        if (i_ctrl.vertex) begin
            r_xi     <= i_vx;
            r_yi     <= i_vy;
            r_lhs    <= prod;
            r_dx_pos <= (dx_new > 0);
            r_span   <= (i_vx > r_x) != (r_xj > r_x);
            if (i_vx < r_minx) r_minx <= i_vx;
            if (i_vx > r_maxx) r_maxx <= i_vx;
            if (i_vy < r_miny) r_miny <= i_vy;
            if (i_vy > r_maxy) r_maxy <= i_vy;
        end
        if (i_ctrl.crossing) begin
            r_xj  <= r_xi;
            r_yj  <= r_yi;
            r_par <= r_par ^ toggle;
        end
    end

    assign o_done   = r_done;
    assign o_inside = r_inside;

endmodule
